### sv/assert_macros.svh
// Assertion helpers, included by the deframer top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk outside reset.
`define C8PD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define C8PD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/c8pd_pkg.sv
`default_nettype none
package c8pd_pkg;

  localparam int BYTE_W     = 8;
  localparam int EV_W       = 3;
  localparam int CNT_W      = 32;  // internal frame counter width, wraps
  localparam int OUT_CNT_W  = 32;
  localparam int CFG_IDX_W  = 3;

  // result events
  localparam logic [EV_W-1:0] EV_SKIP      = 3'd0;
  localparam logic [EV_W-1:0] EV_HDR       = 3'd1;
  localparam logic [EV_W-1:0] EV_PAYLOAD   = 3'd2;
  localparam logic [EV_W-1:0] EV_GOOD      = 3'd3;
  localparam logic [EV_W-1:0] EV_BAD_LEN   = 3'd4;
  localparam logic [EV_W-1:0] EV_CHK_FAIL  = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_HEADER   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_REFLECT   = 3'd4;

  localparam logic [BYTE_W-1:0] HDR_LONG  = 8'd6;
  localparam logic [BYTE_W-1:0] HDR_SHORT = 8'd4;

  typedef struct packed {
    logic [BYTE_W-1:0] start_marker;
    logic              long_header;
    logic [BYTE_W-1:0] max_frame_len;
    logic [BYTE_W-1:0] crc_poly;
    logic              crc_reflect;
  } cfg_t;

  typedef struct packed {
    logic [EV_W-1:0]      event_res;
    logic [BYTE_W-1:0]    payload_byte;
    logic [BYTE_W-1:0]    payload_index;
    logic [BYTE_W-1:0]    msg_id;
    logic [BYTE_W-1:0]    src_dev;
    logic [BYTE_W-1:0]    dest_dev;
    logic [BYTE_W-1:0]    payload_len;
    logic                 crc_match;
    logic                 sum_match;
    logic [OUT_CNT_W-1:0] good_frames;
    logic [OUT_CNT_W-1:0] bad_frames;
  } result_t;

  // one byte of CRC-8, bitwise, either shift direction
  function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] din,
                                                  input logic [BYTE_W-1:0] poly,
                                                  input logic              reflect);
    logic [BYTE_W-1:0] c;
    c = crc ^ din;
    for (int i = 0; i < BYTE_W; i++) begin
      if (reflect) begin
        c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
      end else begin
        c = c[BYTE_W-1] ? ((c << 1) ^ poly) : (c << 1);
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### sv/c8pd_cfg_regs.sv
`default_nettype none
module c8pd_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             wr_en,
  input  wire logic [c8pd_pkg::CFG_IDX_W-1:0]   wr_index,
  input  wire logic [c8pd_pkg::BYTE_W-1:0]      wr_data,
  output c8pd_pkg::cfg_t                        cfg
);
  import c8pd_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_START_MARKER:  cfg_nxt.start_marker  = wr_data;
        CFG_LONG_HEADER:   cfg_nxt.long_header   = wr_data[0];
        CFG_MAX_FRAME_LEN: cfg_nxt.max_frame_len = wr_data;
        CFG_CRC_POLY:      cfg_nxt.crc_poly      = wr_data;
        CFG_CRC_REFLECT:   cfg_nxt.crc_reflect   = wr_data[0];
        default:           cfg_nxt = cfg_r;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_marker  <= 8'hA6;
      cfg_r.long_header   <= 1'b1;
      cfg_r.max_frame_len <= 8'd255;
      cfg_r.crc_poly      <= 8'h07;
      cfg_r.crc_reflect   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

### sv/c8pd_core.sv
`default_nettype none
module c8pd_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         step_en,
  input  wire logic [c8pd_pkg::BYTE_W-1:0]  rx_byte,
  input  wire c8pd_pkg::cfg_t               cfg,
  output c8pd_pkg::result_t                 res
);
  import c8pd_pkg::*;

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_CHK  = 2'd3;

  logic [1:0]        phase_r, phase_nxt;
  logic [BYTE_W-1:0] frame_len_r, frame_len_nxt;
  logic [BYTE_W-1:0] pos_r, pos_nxt;
  logic [BYTE_W-1:0] crc_r, crc_nxt;
  logic [BYTE_W-1:0] xor_r, xor_nxt;
  logic [BYTE_W-1:0] msg_r, msg_nxt;
  logic [BYTE_W-1:0] src_r, src_nxt;
  logic [BYTE_W-1:0] dest_r, dest_nxt;
  logic [CNT_W-1:0]  good_r, good_nxt;
  logic [CNT_W-1:0]  bad_r, bad_nxt;

  logic [EV_W-1:0]   ev;
  logic [BYTE_W-1:0] pbyte, pidx, plen;
  logic              cm, sm;
  logic [BYTE_W-1:0] hs, hs_m1, crc_upd, pos_inc;

  always_comb begin
    phase_nxt     = phase_r;
    frame_len_nxt = frame_len_r;
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    xor_nxt       = xor_r;
    msg_nxt       = msg_r;
    src_nxt       = src_r;
    dest_nxt      = dest_r;
    good_nxt      = good_r;
    bad_nxt       = bad_r;
    ev            = EV_SKIP;
    pbyte         = '0;
    pidx          = '0;
    cm            = 1'b0;
    sm            = 1'b0;
    hs            = cfg.long_header ? HDR_LONG : HDR_SHORT;
    hs_m1         = hs - 8'd1;
    crc_upd       = crc8_byte(crc_r, rx_byte, cfg.crc_poly, cfg.crc_reflect);
    pos_inc       = pos_r + 8'd1;

    unique case (phase_r)
      PH_HUNT: begin
        if (rx_byte == cfg.start_marker) begin
          phase_nxt     = PH_LEN;
          pos_nxt       = 8'd1;
          crc_nxt       = '0;
          xor_nxt       = '0;
          frame_len_nxt = '0;
          msg_nxt       = '0;
          src_nxt       = '0;
          dest_nxt      = '0;
          ev            = EV_HDR;
        end
      end
      PH_LEN: begin
        frame_len_nxt = rx_byte;
        pos_nxt       = 8'd2;
        if (rx_byte < hs || rx_byte > cfg.max_frame_len) begin
          phase_nxt = PH_HUNT;
          bad_nxt   = bad_r + CNT_W'(1);
          ev        = EV_BAD_LEN;
        end else begin
          phase_nxt = PH_DATA;
          crc_nxt   = crc_upd;
          xor_nxt   = xor_r ^ rx_byte;
          ev        = EV_HDR;
        end
      end
      PH_DATA: begin
        if (pos_r < hs_m1) begin
          if (pos_r == 8'd2) msg_nxt = rx_byte;
          if (pos_r == 8'd3) src_nxt = rx_byte;
          if (pos_r == 8'd4) dest_nxt = rx_byte;
          ev = EV_HDR;
        end else begin
          ev    = EV_PAYLOAD;
          pbyte = rx_byte;
          pidx  = pos_r - hs_m1;
        end
        crc_nxt = crc_upd;
        xor_nxt = xor_r ^ rx_byte;
        pos_nxt = pos_inc;
        // 9-bit compare: the + 1 on the position cannot wrap
        if (({1'b0, pos_inc} + 9'd1) >= {1'b0, frame_len_r}) begin
          phase_nxt = PH_CHK;
        end
      end
      PH_CHK: begin
        cm = (rx_byte == crc_r);
        sm = (rx_byte == xor_r);
        if (cm || sm) begin
          good_nxt = good_r + CNT_W'(1);
          ev       = EV_GOOD;
        end else begin
          bad_nxt = bad_r + CNT_W'(1);
          ev      = EV_CHK_FAIL;
        end
        pos_nxt   = pos_inc;
        phase_nxt = PH_HUNT;
      end
      default: phase_nxt = PH_HUNT;
    endcase

    plen = (frame_len_nxt > hs) ? (frame_len_nxt - hs) : '0;
    if (ev == EV_SKIP || ev == EV_BAD_LEN) plen = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      frame_len_r <= '0;
      pos_r       <= '0;
      crc_r       <= '0;
      xor_r       <= '0;
      msg_r       <= '0;
      src_r       <= '0;
      dest_r      <= '0;
      good_r      <= '0;
      bad_r       <= '0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      frame_len_r <= frame_len_nxt;
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      xor_r       <= xor_nxt;
      msg_r       <= msg_nxt;
      src_r       <= src_nxt;
      dest_r      <= dest_nxt;
      good_r      <= good_nxt;
      bad_r       <= bad_nxt;
    end
  end

  always_comb begin
    res.event_res     = ev;
    res.payload_byte  = pbyte;
    res.payload_index = pidx;
    res.msg_id        = msg_nxt;
    res.src_dev       = src_nxt;
    res.dest_dev      = dest_nxt;
    res.payload_len   = plen;
    res.crc_match     = cm;
    res.sum_match     = sm;
    res.good_frames   = OUT_CNT_W'(good_nxt);
    res.bad_frames    = OUT_CNT_W'(bad_nxt);
  end

endmodule
`default_nettype wire

### sv/crc8_packet_deframer_unit.sv
// Byte-stream packet deframer with CRC-8 / XOR-sum check. Every received byte
// gives exactly one result word: skipped, header, payload (cut-through, with
// its index), frame good, bad length or check failed, together with the
// current header fields and the wrapping good/bad frame counters. Throughput
// is one byte per clock while the result stream is ready; the result word for a
// byte passes through the input register, then the result register. The rate
// is set by the frame step: bitwise CRC-8 update, length checks and compare.
// Configuration writes are always ready and take effect on the next cycle;
// write them only while no byte is in flight.
`default_nettype none
module crc8_packet_deframer_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input stream
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [7:0]                       in_tdata,   // [7:0] rx_byte
  // result stream
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [7:0] payload_byte, [15:8] payload_index, [23:16] msg_id, [31:24] src_dev,
  // [39:32] dest_dev, [47:40] payload_len, [48] crc_match, [49] sum_match,
  // [81:50] good_frames, [113:82] bad_frames, [119:114] zero
  output logic [119:0]                          out_tdata,
  output logic [2:0]                            out_tuser,  // [2:0] event_res
  // configuration writes
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [c8pd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [c8pd_pkg::BYTE_W-1:0]      cfg_data
);
  import c8pd_pkg::*;

  cfg_t              cfg;
  result_t           res;
  result_t           out_res_r;
  logic              in_valid_r, in_valid_nxt;
  logic [BYTE_W-1:0] in_byte_r;
  logic              out_valid_r, out_valid_nxt;
  logic              adv;
  logic              out_is_payload, out_is_check, out_not_check;
  logic              out_any_match, out_idx_ok, out_good_ok;

  assign cfg_ready = 1'b1;

  c8pd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // a word moves from the input register into the result register
  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  c8pd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .rx_byte (in_byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (adv) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.event_res;
  assign out_tdata  = {6'd0,
                       out_res_r.bad_frames,
                       out_res_r.good_frames,
                       out_res_r.sum_match,
                       out_res_r.crc_match,
                       out_res_r.payload_len,
                       out_res_r.dest_dev,
                       out_res_r.src_dev,
                       out_res_r.msg_id,
                       out_res_r.payload_index,
                       out_res_r.payload_byte};

  assign out_is_payload = out_valid_r && out_res_r.event_res == EV_PAYLOAD;
  assign out_is_check   = out_res_r.event_res == EV_GOOD || out_res_r.event_res == EV_CHK_FAIL;
  assign out_not_check  = out_valid_r && !out_is_check;
  assign out_any_match  = out_res_r.crc_match || out_res_r.sum_match;
  assign out_idx_ok     = out_res_r.payload_index < out_res_r.payload_len;
  assign out_good_ok    = !(out_valid_r && out_res_r.event_res == EV_GOOD) || out_any_match;

`include "assert_macros.svh"

  `C8PD_ASSERT(a_ready_when_empty, !out_valid_r |-> in_tready, "input stalled with empty output")
  `C8PD_ASSERT(a_index_in_payload, out_is_payload |-> out_idx_ok, "payload index past length")
  `C8PD_ASSERT(a_match_only_on_check, out_not_check |-> !out_any_match, "stray match flag")
  `C8PD_ASSERT_ALWAYS(a_good_has_match, !rst_n || out_good_ok, "good frame without a match")

endmodule
`default_nettype wire

### tb/crc8_packet_deframer_unit_tb.sv
module crc8_packet_deframer_unit_tb;
  import c8pd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  // how the check byte of a built frame is chosen
  localparam int CHK_CRC = 0;
  localparam int CHK_SUM = 1;
  localparam int CHK_BAD = 2;
  localparam int CHK_ANY = 3;

  typedef enum logic [1:0] {SEEK, GET_LEN, IN_BODY, GET_CHECK} link_phase_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'd0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [119:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data = '0;

  crc8_packet_deframer_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow registers
  logic [7:0] sh_marker = 8'hA6;
  logic       sh_long = 1'b1;
  logic [7:0] sh_max = 8'd255;
  logic [7:0] sh_poly = 8'h07;
  logic       sh_reflect = 1'b0;

  // deframer state as predicted
  link_phase_t ph = SEEK;
  logic [7:0]  flen = '0, pos = '0, crc_run = '0, xor_run = '0;
  logic [7:0]  hdr_msg = '0, hdr_src = '0, hdr_dst = '0;
  logic [31:0] good_cnt = '0, bad_cnt = '0;

  result_t     expected_words[$];
  result_t     got_word, want_word;
  logic [7:0]  frame_buf[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_left = 0;
  int bytes_sent = 0;
  int words_checked = 0;
  int fail_count = 0;

  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] c;
    c = crc ^ d;
    repeat (8) begin
      if (sh_reflect) begin
        c = c[0] ? ((c >> 1) ^ sh_poly) : (c >> 1);
      end else begin
        c = c[7] ? ((c << 1) ^ sh_poly) : (c << 1);
      end
    end
    return c;
  endfunction

  function automatic int hdr_bytes();
    return sh_long ? int'(HDR_LONG) : int'(HDR_SHORT);
  endfunction

  // one received byte in, one result word out; advances the predicted state
  function automatic result_t deframe_byte(input logic [7:0] b);
    result_t r;
    int      hs;
    int      p;
    r = '0;
    hs = hdr_bytes();
    r.event_res = EV_SKIP;
    case (ph)
      SEEK: begin
        if (b == sh_marker) begin
          ph = GET_LEN;
          pos = 8'd1;
          crc_run = '0;
          xor_run = '0;
          flen = '0;
          hdr_msg = '0;
          hdr_src = '0;
          hdr_dst = '0;
          r.event_res = EV_HDR;
        end
      end
      GET_LEN: begin
        flen = b;
        pos = 8'd2;
        if (int'(b) < hs || b > sh_max) begin
          ph = SEEK;
          bad_cnt = bad_cnt + 1;
          r.event_res = EV_BAD_LEN;
        end else begin
          ph = IN_BODY;
          crc_run = crc_update(crc_run, b);
          xor_run = xor_run ^ b;
          r.event_res = EV_HDR;
        end
      end
      IN_BODY: begin
        p = int'(pos);
        if (p < hs - 1) begin
          if (p == 2) hdr_msg = b;
          else if (p == 3) hdr_src = b;
          else if (p == 4) hdr_dst = b;
          r.event_res = EV_HDR;
        end else begin
          r.event_res = EV_PAYLOAD;
          r.payload_byte = b;
          r.payload_index = 8'(p - (hs - 1));
        end
        crc_run = crc_update(crc_run, b);
        xor_run = xor_run ^ b;
        pos = pos + 8'd1;
        if (int'(pos) + 1 >= int'(flen)) ph = GET_CHECK;
      end
      default: begin
        r.crc_match = (b == crc_run);
        r.sum_match = (b == xor_run);
        if (r.crc_match || r.sum_match) begin
          good_cnt = good_cnt + 1;
          r.event_res = EV_GOOD;
        end else begin
          bad_cnt = bad_cnt + 1;
          r.event_res = EV_CHK_FAIL;
        end
        pos = pos + 8'd1;
        ph = SEEK;
      end
    endcase
    if (int'(flen) > hs && r.event_res != EV_SKIP && r.event_res != EV_BAD_LEN)
      r.payload_len = 8'(int'(flen) - hs);
    r.msg_id = hdr_msg;
    r.src_dev = hdr_src;
    r.dest_dev = hdr_dst;
    r.good_frames = good_cnt;
    r.bad_frames = bad_cnt;
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    fail_count++;
    if (fail_count <= 40)
      $display("ERROR word %0d %s: got %0h, want %0h", words_checked, what, got, want);
  endtask

  task automatic compare_word(input result_t got, input result_t want);
    if (got.event_res != want.event_res) report("event", got.event_res, want.event_res);
    if (got.payload_byte != want.payload_byte)
      report("payload_byte", got.payload_byte, want.payload_byte);
    if (got.payload_index != want.payload_index)
      report("payload_index", got.payload_index, want.payload_index);
    if (got.msg_id != want.msg_id) report("msg_id", got.msg_id, want.msg_id);
    if (got.src_dev != want.src_dev) report("src_dev", got.src_dev, want.src_dev);
    if (got.dest_dev != want.dest_dev) report("dest_dev", got.dest_dev, want.dest_dev);
    if (got.payload_len != want.payload_len)
      report("payload_len", got.payload_len, want.payload_len);
    if (got.crc_match != want.crc_match) report("crc_match", got.crc_match, want.crc_match);
    if (got.sum_match != want.sum_match) report("sum_match", got.sum_match, want.sum_match);
    if (got.good_frames != want.good_frames)
      report("good_frames", got.good_frames, want.good_frames);
    if (got.bad_frames != want.bad_frames)
      report("bad_frames", got.bad_frames, want.bad_frames);
  endtask

  // result side: random ready, plus long hold-offs on request
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_word.event_res     = out_tuser;
      got_word.payload_byte  = out_tdata[7:0];
      got_word.payload_index = out_tdata[15:8];
      got_word.msg_id        = out_tdata[23:16];
      got_word.src_dev       = out_tdata[31:24];
      got_word.dest_dev      = out_tdata[39:32];
      got_word.payload_len   = out_tdata[47:40];
      got_word.crc_match     = out_tdata[48];
      got_word.sum_match     = out_tdata[49];
      got_word.good_frames   = out_tdata[81:50];
      got_word.bad_frames    = out_tdata[113:82];
      if (out_tdata[119:114] != '0) report("pad bits", out_tdata[119:114], 0);
      if (expected_words.size() == 0) begin
        report("word with none expected", out_tuser, 0);
      end else begin
        want_word = expected_words.pop_front();
        compare_word(got_word, want_word);
      end
      words_checked++;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_words.push_back(deframe_byte(b));
    bytes_sent++;
  endtask

  task automatic send_buf_range(input int lo, input int hi);
    for (int i = lo; i < hi; i++) send_byte(frame_buf[i]);
  endtask

  // wait until the pipeline is empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_START_MARKER:  sh_marker = val;
      CFG_LONG_HEADER:   sh_long = val[0];
      CFG_MAX_FRAME_LEN: sh_max = val;
      CFG_CRC_POLY:      sh_poly = val;
      CFG_CRC_REFLECT:   sh_reflect = val[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [7:0] marker, input logic hdr_long,
                           input logic [7:0] max_len, input logic [7:0] poly,
                           input logic reflect);
    write_reg(CFG_START_MARKER, marker);
    write_reg(CFG_LONG_HEADER, {7'd0, hdr_long});
    write_reg(CFG_MAX_FRAME_LEN, max_len);
    write_reg(CFG_CRC_POLY, poly);
    write_reg(CFG_CRC_REFLECT, {7'd0, reflect});
  endtask

  // check byte over the length byte up to the last body byte in frame_buf
  task automatic append_check(input int mode);
    logic [7:0] c, x, v;
    c = '0;
    x = '0;
    for (int i = 1; i < frame_buf.size(); i++) begin
      c = crc_update(c, frame_buf[i]);
      x = x ^ frame_buf[i];
    end
    v = 8'($urandom_range(255));
    case (mode)
      CHK_CRC: v = c;
      CHK_SUM: v = x;
      CHK_BAD: while (v == c || v == x) v = v + 8'd1;
      default: ;
    endcase
    frame_buf.push_back(v);
  endtask

  // marker and length; a body and check byte only if the length is accepted; cut > 0 keeps the first cut bytes
  task automatic send_frame(input int len, input int mode, input int cut);
    frame_buf = {};
    frame_buf.push_back(sh_marker);
    frame_buf.push_back(8'(len));
    if (len >= hdr_bytes() && len <= int'(sh_max)) begin
      for (int i = 2; i < len - 1; i++) frame_buf.push_back(8'($urandom_range(255)));
      append_check(mode);
    end
    while (cut > 0 && frame_buf.size() > cut) void'(frame_buf.pop_back());
    send_buf_range(0, frame_buf.size());
  endtask

  task automatic run_random(input int n);
    int done, kind, hs, len, maxpl, mode;
    done = 0;
    while (done < n) begin
      hs = hdr_bytes();
      kind = $urandom_range(99);
      if (kind >= 93) begin
        // line noise, not counted
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      end else if (kind >= 75 || int'(sh_max) < hs) begin
        if ($urandom_range(1) == 0 || sh_max == 8'd255) len = $urandom_range(0, hs - 1);
        else len = $urandom_range(int'(sh_max) + 1, 255);
        send_frame(len, CHK_CRC, 0);
        done += 2;
      end else begin
        maxpl = int'(sh_max) - hs;
        if ($urandom_range(99) < 90) len = hs + $urandom_range(0, (maxpl < 12) ? maxpl : 12);
        else len = hs + $urandom_range(0, maxpl);
        mode = $urandom_range(CHK_ANY);
        // broken frame: cut short, the next marker lands inside its body
        send_frame(len, mode, (kind >= 67) ? $urandom_range(2, len - 1) : 0);
        done += frame_buf.size();
      end
    end
  endtask

  task automatic test_directed_reset_values();
    send_idle_pct = 33;
    recv_idle_pct = 71;
    // noise, marker, length below the header size
    frame_buf = '{8'h00, 8'hFF, 8'hA6, 8'h05};
    send_buf_range(0, frame_buf.size());
    // good frame by CRC, payload bytes at both extremes
    frame_buf = '{8'hA6, 8'h08, 8'h00, 8'hFF, 8'h80, 8'h00, 8'hFF};
    append_check(CHK_CRC);
    send_buf_range(0, frame_buf.size());
    // check byte equal to the marker does not reopen a frame
    frame_buf = '{8'hA6, 8'h06, 8'h01, 8'h02, 8'h03, 8'hA6, 8'h01};
    send_buf_range(0, frame_buf.size());
    settle();
  endtask

  task automatic test_config_edges();
    // 1-bit registers only keep bit 0
    write_reg(CFG_START_MARKER, 8'h00);
    write_reg(CFG_LONG_HEADER, 8'hFE);
    write_reg(CFG_MAX_FRAME_LEN, 8'd4);
    write_reg(CFG_CRC_POLY, 8'hFF);
    write_reg(CFG_CRC_REFLECT, 8'hFF);
    write_reg(CFG_UNUSED_IDX, 8'h5A);
    // shortest short frame, good by sum; then a length above the maximum
    frame_buf = '{8'h00, 8'h04, 8'hFF};
    append_check(CHK_SUM);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'h05);
    send_buf_range(0, frame_buf.size());
    settle();
    // header size switched in the middle of a frame
    write_reg(CFG_MAX_FRAME_LEN, 8'd255);
    frame_buf = '{8'h00, 8'h0A, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77};
    append_check(CHK_CRC);
    send_buf_range(0, 3);
    settle();
    write_reg(CFG_LONG_HEADER, 8'h01);
    send_buf_range(3, frame_buf.size());
    settle();
  endtask

  task automatic test_random_sender_idle();
    send_idle_pct = 33;
    recv_idle_pct = 71;
    write_all(8'hA6, 1'b1, 8'd255, 8'h31, 1'b0);
    run_random(230);
    settle();
  endtask

  task automatic test_random_receiver_idle();
    send_idle_pct = 71;
    recv_idle_pct = 33;
    write_all(8'h00, 1'b0, 8'd40, 8'h8C, 1'b1);
    run_random(230);
    settle();
  endtask

  // maximum below the long header size: every frame is rejected
  task automatic test_rejecting_config();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_all(8'hFF, 1'b1, 8'd4, 8'h00, 1'b0);
    run_random(60);
    settle();
  endtask

  task automatic test_reflected_long_payload();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_all(8'h7E, 1'b0, 8'd255, 8'hFF, 1'b1);
    send_frame(255, CHK_CRC, 0);
    run_random(150);
    settle();
  endtask

  task automatic test_back_pressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_all(8'h5A, 1'b1, 8'd255, 8'h07, 1'b0);
    stall_left = 300;
    run_random(80);
    settle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_reset_values();
    test_config_edges();
    test_random_sender_idle();
    test_random_receiver_idle();
    test_rejecting_config();
    test_reflected_long_payload();
    test_back_pressure();
    settle();
    repeat (20) @(posedge clk);
    $display("run covered %0d bytes and %0d result words over seven register setups,",
             bytes_sent, words_checked);
    $display("with %0d frames accepted and %0d rejected, both header sizes, CRC directions",
             good_cnt, bad_cnt);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("crc8_packet_deframer_unit: match");
    end else begin
      $display("crc8_packet_deframer_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout with %0d words outstanding", expected_words.size());
    $display("crc8_packet_deframer_unit: mismatch");
    $finish;
  end

endmodule
